>>> sv/btrb_pkg.sv
// Shared types and codes for the button toggle relay bank.
// Holds the request and register codes, the channel record and the result layout.
// No dependencies.
`default_nettype none
package btrb_pkg;

	typedef enum logic [2:0] {
		REQ_SCAN       = 3'd0,
		REQ_SET        = 3'd1,
		REQ_TOGGLE     = 3'd2,
		REQ_QUERY      = 3'd3,
		REQ_ENABLE     = 3'd4,
		REQ_DISABLE    = 3'd5,
		REQ_TAKE_DIRTY = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		CFG_BLOCK_ENABLE  = 3'd0,
		CFG_COOLDOWN_MS   = 3'd1,
		CFG_BUTTON_INVERT = 3'd2,
		CFG_RELAY_INVERT  = 3'd3,
		CFG_BUTTON_MASK   = 3'd4,
		CFG_RELAY_MASK    = 3'd5
	} cfg_idx_t;

	localparam int unsigned CHAN_W  = 4;
	localparam int unsigned MASK_W  = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CD_W    = 16;

	localparam logic        BLOCK_ENABLE_RST = 1'b1;
	localparam logic [15:0] COOLDOWN_RST     = 16'd200;

	typedef struct packed {
		logic              enabled;
		logic              btn_captured;
		logic              energized;
		logic              btn_prev;
		logic              idle_button;
		logic [TIME_W-1:0] deadline;
	} chan_rec_t;

	typedef struct packed {
		logic            block_enable;
		logic [CD_W-1:0] cooldown_ms;
		logic            button_invert;
		logic            relay_invert;
	} cfg_t;

	typedef struct packed {
		logic ok;
		logic relay_state;
		logic relay_written;
		logic relay_drive;
		logic dirty_flag;
	} res_t;

endpackage
`default_nettype wire

>>> sv/btrb_chan_file.sv
// Per-channel record store: one read port, one write port, cleared on reset.
// Depends on btrb_pkg for the record layout.
`default_nettype none
module btrb_chan_file #(
	parameter int CHANNELS = 16,
	parameter int IDX_W    = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [IDX_W-1:0]    rd_idx,
	output btrb_pkg::chan_rec_t      rd_rec,
	input  wire logic                we,
	input  wire logic [IDX_W-1:0]    wr_idx,
	input  wire btrb_pkg::chan_rec_t wr_rec
);

	btrb_pkg::chan_rec_t rec_q [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rec_q[i] <= '0;
			end
		end else if (we) begin
			rec_q[wr_idx] <= wr_rec;
		end
	end

	assign rd_rec = rec_q[rd_idx];

endmodule
`default_nettype wire

>>> sv/btrb_exec.sv
// Request decode and record update for one transaction: next record, pending flag
// and result fields. Purely combinational. Depends on btrb_pkg.
`default_nettype none
module btrb_exec (
	input  wire btrb_pkg::req_t               req,
	input  wire logic                         in_range,
	input  wire logic                         btn_fit,
	input  wire logic                         rly_fit,
	input  wire logic                         button_level,
	input  wire logic [btrb_pkg::TIME_W-1:0]  now_ms,
	input  wire logic                         relay_value,
	input  wire btrb_pkg::cfg_t               cfg,
	input  wire btrb_pkg::chan_rec_t          rec,
	input  wire logic                         pending,
	output btrb_pkg::chan_rec_t               rec_next,
	output logic                              rec_we,
	output logic                              pending_next,
	output btrb_pkg::res_t                    res
);

	logic                        pressed;
	logic                        usable;
	logic                        in_cooldown;
	logic [btrb_pkg::TIME_W-1:0] elapsed;
	logic [btrb_pkg::TIME_W-1:0] new_deadline;
	logic                        written;
	logic                        ok;
	logic                        valid_req;

	assign pressed      = button_level ^ cfg.button_invert;
	assign usable       = cfg.block_enable & rec.enabled & rly_fit;
	assign elapsed      = now_ms - rec.deadline;
	assign in_cooldown  = (rec.deadline != '0) && elapsed[btrb_pkg::TIME_W-1];
	assign new_deadline = now_ms + {{(btrb_pkg::TIME_W - btrb_pkg::CD_W){1'b0}}, cfg.cooldown_ms};

	always_comb begin
		rec_next     = rec;
		pending_next = pending;
		written      = 1'b0;
		ok           = 1'b0;
		valid_req    = 1'b1;
		case (req)
			btrb_pkg::REQ_SCAN: begin
				if (usable && rec.btn_captured) begin
					ok = 1'b1;
					if (!in_cooldown && pressed != rec.idle_button &&
						rec.btn_prev == rec.idle_button) begin
						rec_next.energized = ~rec.energized;
						rec_next.deadline  = new_deadline;
						written            = 1'b1;
						pending_next       = 1'b1;
					end
					rec_next.btn_prev = pressed;
				end
			end
			btrb_pkg::REQ_SET, btrb_pkg::REQ_TOGGLE: begin
				if (usable) begin
					ok = 1'b1;
					if (req == btrb_pkg::REQ_TOGGLE || rec.energized != relay_value) begin
						rec_next.energized = (req == btrb_pkg::REQ_TOGGLE) ?
							~rec.energized : relay_value;
						written      = 1'b1;
						pending_next = 1'b1;
						if (rec.btn_captured && btn_fit) begin
							rec_next.btn_prev    = pressed;
							rec_next.idle_button = pressed;
						end
					end
				end
			end
			btrb_pkg::REQ_QUERY: begin
				ok = usable;
			end
			btrb_pkg::REQ_ENABLE: begin
				ok                    = 1'b1;
				rec_next              = '0;
				rec_next.enabled      = 1'b1;
				rec_next.btn_captured = btn_fit;
				rec_next.btn_prev     = btn_fit & pressed;
				rec_next.idle_button  = btn_fit & pressed;
				written               = rly_fit;
				pending_next          = 1'b1;
			end
			btrb_pkg::REQ_DISABLE: begin
				ok           = 1'b1;
				rec_next     = '0;
				written      = rly_fit;
				pending_next = 1'b1;
			end
			btrb_pkg::REQ_TAKE_DIRTY: begin
				ok           = 1'b1;
				pending_next = 1'b0;
			end
			default: begin
				valid_req = 1'b0;
			end
		endcase

		// take dirty ignores the channel; everything else needs it in range
		if (req != btrb_pkg::REQ_TAKE_DIRTY && !in_range) begin
			rec_next     = rec;
			pending_next = pending;
			written      = 1'b0;
			ok           = 1'b0;
			valid_req    = 1'b0;
		end
	end

	assign rec_we = valid_req && req != btrb_pkg::REQ_TAKE_DIRTY;

	always_comb begin
		res               = '0;
		res.ok            = ok;
		res.relay_written = written;
		if (rec_we) begin
			res.relay_state = rec_next.energized;
			res.relay_drive = written & (rec_next.energized ^ cfg.relay_invert);
		end
		if (req == btrb_pkg::REQ_TAKE_DIRTY) begin
			res.dirty_flag = pending;
		end
	end

endmodule
`default_nettype wire

>>> sv/button_toggle_relay_bank.sv
// Button toggle relay bank: a register file of per-channel records and request logic.
// Depends on btrb_pkg, btrb_chan_file and btrb_exec.
//
// Usage:
//   Requests enter on the in channel (in_valid/in_ready) with req_type, channel,
//   button_level, now_ms and relay_value. Each request gives exactly one result on
//   the out channel (out_valid/out_ready): ok, relay_state, relay_written,
//   relay_drive and dirty_flag, in request order.
//   A request is registered on entry, then its channel record is read, updated and
//   written back as the result register loads, so out_valid rises after the entry
//   and result registers; one request per cycle is sustained while out_ready is high,
//   set by the single read-modify-write of the record file.
//   Registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data); cfg_ready is always high, unknown indexes are dropped. Write them only
//   while no request is in flight.
//   Reset clears every record and the pending flag, block_enable=1, cooldown 200 ms,
//   other registers 0. No clearing pass: the block takes requests right after reset.
//   When out_ready is low the result holds, the entry stage fills, and in_ready
//   drops only once both are occupied.
`default_nettype none
module button_toggle_relay_bank #(
	parameter int CHANNELS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [3:0]  channel,
	input  wire logic        button_level,
	input  wire logic [31:0] now_ms,
	input  wire logic        relay_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic             relay_state,
	output logic             relay_written,
	output logic             relay_drive,
	output logic             dirty_flag,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// configuration registers
	btrb_pkg::cfg_t   cfg_q;
	logic [15:0]      button_mask_q;
	logic [15:0]      relay_mask_q;

	// entry stage
	logic             valid_s1;
	btrb_pkg::req_t   req_s1;
	logic [3:0]       chan_s1;
	logic             button_s1;
	logic [31:0]      now_s1;
	logic             relay_value_s1;

	logic             out_valid_q;
	btrb_pkg::res_t   res_q;
	logic             pending_q;

	logic                    advance;
	logic [IDX_W+3:0]        chan_ext;
	logic [IDX_W-1:0]        idx;
	logic                    in_range;
	btrb_pkg::chan_rec_t     rec_rd;
	btrb_pkg::chan_rec_t     rec_next;
	logic                    rec_we;
	logic                    pending_next;
	btrb_pkg::res_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_enable  <= btrb_pkg::BLOCK_ENABLE_RST;
			cfg_q.cooldown_ms   <= btrb_pkg::COOLDOWN_RST;
			cfg_q.button_invert <= 1'b0;
			cfg_q.relay_invert  <= 1'b0;
			button_mask_q       <= '0;
			relay_mask_q        <= '0;
		end else if (cfg_valid) begin
			case (btrb_pkg::cfg_idx_t'(cfg_index))
				btrb_pkg::CFG_BLOCK_ENABLE:  cfg_q.block_enable  <= cfg_data[0];
				btrb_pkg::CFG_COOLDOWN_MS:   cfg_q.cooldown_ms   <= cfg_data;
				btrb_pkg::CFG_BUTTON_INVERT: cfg_q.button_invert <= cfg_data[0];
				btrb_pkg::CFG_RELAY_INVERT:  cfg_q.relay_invert  <= cfg_data[0];
				btrb_pkg::CFG_BUTTON_MASK:   button_mask_q       <= cfg_data;
				btrb_pkg::CFG_RELAY_MASK:    relay_mask_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1         <= btrb_pkg::req_t'(req_type);
			chan_s1        <= channel;
			button_s1      <= button_level;
			now_s1         <= now_ms;
			relay_value_s1 <= relay_value;
		end
	end

	assign chan_ext = {{IDX_W{1'b0}}, chan_s1};
	assign idx      = chan_ext[IDX_W-1:0];
	assign in_range = 32'(chan_s1) < CHANNELS;

	btrb_chan_file #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_chan_file (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx),
		.rd_rec (rec_rd),
		.we     (advance && rec_we),
		.wr_idx (idx),
		.wr_rec (rec_next)
	);

	btrb_exec u_exec (
		.req          (req_s1),
		.in_range     (in_range),
		.btn_fit      (button_mask_q[chan_s1]),
		.rly_fit      (relay_mask_q[chan_s1]),
		.button_level (button_s1),
		.now_ms       (now_s1),
		.relay_value  (relay_value_s1),
		.cfg          (cfg_q),
		.rec          (rec_rd),
		.pending      (pending_q),
		.rec_next     (rec_next),
		.rec_we       (rec_we),
		.pending_next (pending_next),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pending_q   <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				pending_q   <= pending_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = res_q.ok;
	assign relay_state   = res_q.relay_state;
	assign relay_written = res_q.relay_written;
	assign relay_drive   = res_q.relay_drive;
	assign dirty_flag    = res_q.dirty_flag;

endmodule
`default_nettype wire

>>> sv/btrb_checker.sv
// Port-level checks for button_toggle_relay_bank, attached by bind.
// Watches only the result channel; no package dependency.
`default_nettype none
module btrb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic ok,
	input wire logic relay_state,
	input wire logic relay_written,
	input wire logic relay_drive,
	input wire logic dirty_flag
);

	// a stalled result keeps its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({ok, relay_state, relay_written, relay_drive, dirty_flag}))
		else $error("result changed while stalled");

	// pin level is only reported when the pin was driven
	a_drive_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && relay_drive |-> relay_written)
		else $error("relay_drive without relay_written");

	// refused requests never drive the pin
	a_write_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && relay_written |-> ok)
		else $error("relay_written on a refused transaction");

	// dirty flag only comes from take-dirty, which reports relay off and no write
	a_dirty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dirty_flag |-> ok && !relay_state && !relay_written)
		else $error("dirty_flag on a non take-dirty result");

endmodule

bind button_toggle_relay_bank btrb_checker u_btrb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.ok            (ok),
	.relay_state   (relay_state),
	.relay_written (relay_written),
	.relay_drive   (relay_drive),
	.dirty_flag    (dirty_flag)
);
`default_nettype wire
